// ===== sv/bta_pkg.sv =====
// Package for the boundary-tag heap allocator: constants, codes, types and init table.
`timescale 1ns / 1ps
package bta_pkg;

    localparam int HEAP_WORDS_DEF = 4096;
    localparam int INIT_CHUNK     = 1 << 8;
    localparam int ALIGN_BYTES    = 8;
    localparam int ALIGN_MASK     = 'h7;
    localparam int ALLOC_BIT      = 'h01;

    localparam int REQ_W   = 14;
    localparam int ADDR_W  = 12;
    localparam int GROW_W  = 13;
    localparam int STAT_W  = 2;
    localparam int INIT_N  = 6;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOMEM   = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        FN_ALLOC = 1'b0,
        FN_FREE  = 1'b1
    } func_t;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE,
        S_A_RD, S_A_CHK, S_G_CHK, S_G_W1, S_G_W2,
        S_P_DEC, S_PS_HDR, S_PS_FTR, S_PS_NEXT, S_PS_HDR2, S_PS_FTR2,
        S_PN_HDR, S_PN_FTR,
        S_F_RD, S_F_CHK, S_F_HDR, S_F_FTR, S_F_RDP, S_F_CHKP,
        S_F_HDR2, S_F_FTR2, S_F_RDN, S_F_CHKN, S_F_HDR3, S_F_FTR3
    } state_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_INIT,
        DP_LOAD,
        DP_RD_CUR,
        DP_STEP,
        DP_FOUND,
        DP_GROW_W1,
        DP_GROW_W2,
        DP_SPLIT_PREP,
        DP_SET_DATA,
        DP_WR_HDR_A,
        DP_WR_FTR_A,
        DP_WR_HDR_F,
        DP_WR_FTR_F,
        DP_NEXT_BLK,
        DP_RD_PREV,
        DP_MERGE_PREV,
        DP_RD_NEXT,
        DP_MERGE_NEXT
    } dp_cmd_t;

    typedef struct packed {
        logic init_last;
        logic in_free;
        logic in_bad;
        logic cur_in;
        logic q_size_zero;
        logic q_used;
        logic q_fits;
        logic cur_gt_hdr;
        logic cur_eq_hdr;
        logic grow_fail;
        logic split;
        logic next_in;
    } dp_status_t;

    // Initial heap: prologue, one free block spanning the first chunk, epilogue.
    function automatic logic [8:0] init_addr(input logic [2:0] idx);
        logic [8:0] a;
        begin
            unique case (idx)
                3'd0:    a = 9'd0;
                3'd1:    a = 9'd1;
                3'd2:    a = 9'd2;
                3'd3:    a = 9'(INIT_CHUNK - 3);
                3'd4:    a = 9'(INIT_CHUNK - 2);
                3'd5:    a = 9'(INIT_CHUNK - 1);
                default: a = 9'd0;
            endcase
            return a;
        end
    endfunction

    function automatic logic [9:0] init_tag(input logic [2:0] idx);
        logic [9:0] t;
        begin
            unique case (idx)
                3'd2, 3'd3: t = 10'((INIT_CHUNK - 6) << 1);
                default:    t = 10'(ALLOC_BIT);
            endcase
            return t;
        end
    endfunction

endpackage

// ===== sv/bta_dp.sv =====
// Datapath of the heap allocator: heap memory, block pointers and size arithmetic.
`timescale 1ns / 1ps
module bta_dp #(
    parameter int HEAP_WORDS = bta_pkg::HEAP_WORDS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bta_pkg::dp_cmd_t            cmd,
    input  logic                        func,
    input  logic [bta_pkg::REQ_W-1:0]   request_bytes,
    input  logic [bta_pkg::ADDR_W-1:0]  free_addr,
    input  logic                        cfg_we,
    input  logic [bta_pkg::GROW_W-1:0]  cfg_data,
    output bta_pkg::dp_status_t         st,
    output logic [bta_pkg::ADDR_W-1:0]  res_data
);

    localparam int AW = $clog2(HEAP_WORDS);
    localparam int CW = ((AW > 13) ? AW : 13) + 2;

    logic [AW:0]   mem [HEAP_WORDS];
    logic [AW:0]   mem_q_reg;

    logic [CW-1:0] cur_reg, cur_next;
    logic [CW-1:0] p_reg, p_next;
    logic [CW-1:0] s_reg, s_next;
    logic [CW-1:0] t_reg, t_next;
    logic [CW-1:0] need_reg, need_next;
    logic [CW-1:0] hdr_reg, hdr_next;
    logic [CW-1:0] end_reg, end_next;
    logic [bta_pkg::GROW_W-1:0] gc_reg;
    logic [2:0]    init_reg, init_next;
    logic [bta_pkg::ADDR_W-1:0] data_reg, data_next;

    logic          wr_en, rd_en;
    logic [CW-1:0] wr_addr, rd_addr;
    logic [AW:0]   wr_data;
    logic [CW-1:0] q_size, grow, need_in, need2;

    assign q_size  = CW'(mem_q_reg[AW:1]);
    assign need2   = need_reg + CW'(2);
    assign grow    = (CW'(gc_reg) < need2) ? need2 : CW'(gc_reg);
    assign need_in = CW'(((CW'(request_bytes) + CW'(bta_pkg::ALIGN_BYTES - 1))
                     & ~CW'(bta_pkg::ALIGN_MASK)) >> 2);

    always_comb
    begin
        st.init_last   = (init_reg == 3'(bta_pkg::INIT_N - 1));
        st.in_free     = (func == bta_pkg::FN_FREE);
        st.in_bad      = (func == bta_pkg::FN_FREE) ? (free_addr == '0)
                                                    : (request_bytes == '0);
        st.cur_in      = (cur_reg + CW'(1)) < end_reg;
        st.q_size_zero = (q_size == '0);
        st.q_used      = mem_q_reg[0];
        st.q_fits      = (q_size >= need_reg);
        st.cur_gt_hdr  = (cur_reg > hdr_reg);
        st.cur_eq_hdr  = (cur_reg == hdr_reg);
        st.grow_fail   = (end_reg + grow) > CW'(HEAP_WORDS);
        st.split       = (s_reg > need2);
        st.next_in     = (p_reg + s_reg + CW'(2)) < end_reg;
    end

    always_comb
    begin
        cur_next  = cur_reg;
        p_next    = p_reg;
        s_next    = s_reg;
        t_next    = t_reg;
        need_next = need_reg;
        hdr_next  = hdr_reg;
        end_next  = end_reg;
        init_next = init_reg;
        data_next = data_reg;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        wr_addr   = p_reg;
        wr_data   = {s_reg[AW-1:0], 1'b0};
        rd_addr   = cur_reg;
        unique case (cmd)
            bta_pkg::DP_INIT:
            begin
                wr_en     = 1'b1;
                wr_addr   = CW'(bta_pkg::init_addr(init_reg));
                wr_data   = (AW+1)'(bta_pkg::init_tag(init_reg));
                init_next = init_reg + 3'd1;
            end
            bta_pkg::DP_LOAD:
            begin
                need_next = need_in;
                hdr_next  = CW'(free_addr) - CW'(1);
                cur_next  = CW'(2);
                data_next = '0;
            end
            bta_pkg::DP_RD_CUR:     rd_en = 1'b1;
            bta_pkg::DP_STEP:       cur_next = cur_reg + q_size + CW'(2);
            bta_pkg::DP_FOUND:
            begin
                p_next = cur_reg;
                s_next = q_size;
            end
            bta_pkg::DP_GROW_W1:
            begin
                wr_en   = 1'b1;
                wr_addr = end_reg - CW'(2) + grow;
                wr_data = (AW+1)'(bta_pkg::ALLOC_BIT);
            end
            bta_pkg::DP_GROW_W2:
            begin
                wr_en    = 1'b1;
                wr_addr  = end_reg - CW'(1) + grow;
                wr_data  = (AW+1)'(bta_pkg::ALLOC_BIT);
                end_next = end_reg + grow;
                p_next   = end_reg - CW'(2);
                s_next   = grow - CW'(2);
            end
            bta_pkg::DP_SPLIT_PREP:
            begin
                t_next    = s_reg - need2;
                s_next    = need_reg;
                data_next = bta_pkg::ADDR_W'(p_reg + CW'(1));
            end
            bta_pkg::DP_SET_DATA:   data_next = bta_pkg::ADDR_W'(p_reg + CW'(1));
            bta_pkg::DP_WR_HDR_A:
            begin
                wr_en   = 1'b1;
                wr_data = {s_reg[AW-1:0], 1'b1};
            end
            bta_pkg::DP_WR_FTR_A:
            begin
                wr_en   = 1'b1;
                wr_addr = p_reg + s_reg + CW'(1);
                wr_data = {s_reg[AW-1:0], 1'b1};
            end
            bta_pkg::DP_WR_HDR_F:   wr_en = 1'b1;
            bta_pkg::DP_WR_FTR_F:
            begin
                wr_en   = 1'b1;
                wr_addr = p_reg + s_reg + CW'(1);
            end
            bta_pkg::DP_NEXT_BLK:
            begin
                p_next = p_reg + s_reg + CW'(2);
                s_next = t_reg;
            end
            bta_pkg::DP_RD_PREV:
            begin
                rd_en   = 1'b1;
                rd_addr = p_reg - CW'(1);
            end
            bta_pkg::DP_MERGE_PREV:
            begin
                p_next = p_reg - q_size - CW'(2);
                s_next = s_reg + q_size + CW'(2);
            end
            bta_pkg::DP_RD_NEXT:
            begin
                rd_en   = 1'b1;
                rd_addr = p_reg + s_reg + CW'(2);
            end
            bta_pkg::DP_MERGE_NEXT: s_next = s_reg + q_size + CW'(2);
            default:                ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        p_reg    <= p_next;
        s_reg    <= s_next;
        t_reg    <= t_next;
        need_reg <= need_next;
        hdr_reg  <= hdr_next;
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_reg  <= CW'(bta_pkg::INIT_CHUNK);
            gc_reg   <= bta_pkg::GROW_W'(bta_pkg::INIT_CHUNK);
            init_reg <= '0;
        end
        else
        begin
            end_reg  <= end_next;
            init_reg <= init_next;
            if (cfg_we)
            begin
                gc_reg <= cfg_data;
            end
        end
    end

    assign res_data = data_reg;

`ifndef NO_ASSERTIONS
    // The heap never grows past its memory.
    a_end_bound: assert property (@(posedge clk) disable iff (!rst_n)
        end_reg <= CW'(HEAP_WORDS))
        else $error("heap end beyond memory");
`endif

endmodule

// ===== sv/bta_ctrl.sv =====
// Controller of the heap allocator: sequences scans, growth, placement and merges.
`timescale 1ns / 1ps
module bta_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  bta_pkg::dp_status_t          st,
    output bta_pkg::dp_cmd_t             cmd,
    output logic                         busy,
    output logic                         done,
    output logic [bta_pkg::STAT_W-1:0]   status
);

    bta_pkg::state_t  state_reg, state_next;
    logic             done_reg, done_next;
    bta_pkg::status_t status_reg, status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bta_pkg::S_INIT;
            done_reg   <= 1'b0;
            status_reg <= bta_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = bta_pkg::DP_NOP;
        done_next   = 1'b0;
        status_next = status_reg;
        unique case (state_reg)
            bta_pkg::S_INIT:
            begin
                cmd = bta_pkg::DP_INIT;
                if (st.init_last)
                begin
                    state_next = bta_pkg::S_IDLE;
                end
            end
            bta_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd = bta_pkg::DP_LOAD;
                    if (st.in_bad)
                    begin
                        done_next   = 1'b1;
                        status_next = bta_pkg::ST_IGNORED;
                    end
                    else if (st.in_free)
                    begin
                        state_next = bta_pkg::S_F_RD;
                    end
                    else
                    begin
                        state_next = bta_pkg::S_A_RD;
                    end
                end
            end
            bta_pkg::S_A_RD:
            begin
                if (st.cur_in)
                begin
                    cmd        = bta_pkg::DP_RD_CUR;
                    state_next = bta_pkg::S_A_CHK;
                end
                else
                begin
                    state_next = bta_pkg::S_G_CHK;
                end
            end
            bta_pkg::S_A_CHK:
            begin
                if (st.q_size_zero)
                begin
                    state_next = bta_pkg::S_G_CHK;
                end
                else if (!st.q_used && st.q_fits)
                begin
                    cmd        = bta_pkg::DP_FOUND;
                    state_next = bta_pkg::S_P_DEC;
                end
                else
                begin
                    cmd        = bta_pkg::DP_STEP;
                    state_next = bta_pkg::S_A_RD;
                end
            end
            bta_pkg::S_G_CHK:
            begin
                if (st.grow_fail)
                begin
                    done_next   = 1'b1;
                    status_next = bta_pkg::ST_NOMEM;
                    state_next  = bta_pkg::S_IDLE;
                end
                else
                begin
                    state_next = bta_pkg::S_G_W1;
                end
            end
            bta_pkg::S_G_W1:
            begin
                cmd        = bta_pkg::DP_GROW_W1;
                state_next = bta_pkg::S_G_W2;
            end
            bta_pkg::S_G_W2:
            begin
                cmd        = bta_pkg::DP_GROW_W2;
                state_next = bta_pkg::S_P_DEC;
            end
            bta_pkg::S_P_DEC:
            begin
                if (st.split)
                begin
                    cmd        = bta_pkg::DP_SPLIT_PREP;
                    state_next = bta_pkg::S_PS_HDR;
                end
                else
                begin
                    cmd        = bta_pkg::DP_SET_DATA;
                    state_next = bta_pkg::S_PN_HDR;
                end
            end
            bta_pkg::S_PS_HDR:
            begin
                cmd        = bta_pkg::DP_WR_HDR_A;
                state_next = bta_pkg::S_PS_FTR;
            end
            bta_pkg::S_PS_FTR:
            begin
                cmd        = bta_pkg::DP_WR_FTR_A;
                state_next = bta_pkg::S_PS_NEXT;
            end
            bta_pkg::S_PS_NEXT:
            begin
                cmd        = bta_pkg::DP_NEXT_BLK;
                state_next = bta_pkg::S_PS_HDR2;
            end
            bta_pkg::S_PS_HDR2:
            begin
                cmd        = bta_pkg::DP_WR_HDR_F;
                state_next = bta_pkg::S_PS_FTR2;
            end
            bta_pkg::S_PS_FTR2:
            begin
                cmd         = bta_pkg::DP_WR_FTR_F;
                done_next   = 1'b1;
                status_next = bta_pkg::ST_OK;
                state_next  = bta_pkg::S_IDLE;
            end
            bta_pkg::S_PN_HDR:
            begin
                cmd        = bta_pkg::DP_WR_HDR_A;
                state_next = bta_pkg::S_PN_FTR;
            end
            bta_pkg::S_PN_FTR:
            begin
                cmd         = bta_pkg::DP_WR_FTR_A;
                done_next   = 1'b1;
                status_next = bta_pkg::ST_OK;
                state_next  = bta_pkg::S_IDLE;
            end
            bta_pkg::S_F_RD:
            begin
                if (st.cur_in)
                begin
                    cmd        = bta_pkg::DP_RD_CUR;
                    state_next = bta_pkg::S_F_CHK;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = bta_pkg::ST_IGNORED;
                    state_next  = bta_pkg::S_IDLE;
                end
            end
            bta_pkg::S_F_CHK:
            begin
                if (st.q_size_zero || st.cur_gt_hdr || (st.cur_eq_hdr && !st.q_used))
                begin
                    done_next   = 1'b1;
                    status_next = bta_pkg::ST_IGNORED;
                    state_next  = bta_pkg::S_IDLE;
                end
                else if (st.cur_eq_hdr)
                begin
                    cmd        = bta_pkg::DP_FOUND;
                    state_next = bta_pkg::S_F_HDR;
                end
                else
                begin
                    cmd        = bta_pkg::DP_STEP;
                    state_next = bta_pkg::S_F_RD;
                end
            end
            bta_pkg::S_F_HDR:
            begin
                cmd        = bta_pkg::DP_WR_HDR_F;
                state_next = bta_pkg::S_F_FTR;
            end
            bta_pkg::S_F_FTR:
            begin
                cmd        = bta_pkg::DP_WR_FTR_F;
                state_next = bta_pkg::S_F_RDP;
            end
            bta_pkg::S_F_RDP:
            begin
                cmd        = bta_pkg::DP_RD_PREV;
                state_next = bta_pkg::S_F_CHKP;
            end
            bta_pkg::S_F_CHKP:
            begin
                if (!st.q_used)
                begin
                    cmd        = bta_pkg::DP_MERGE_PREV;
                    state_next = bta_pkg::S_F_HDR2;
                end
                else
                begin
                    state_next = bta_pkg::S_F_RDN;
                end
            end
            bta_pkg::S_F_HDR2:
            begin
                cmd        = bta_pkg::DP_WR_HDR_F;
                state_next = bta_pkg::S_F_FTR2;
            end
            bta_pkg::S_F_FTR2:
            begin
                cmd        = bta_pkg::DP_WR_FTR_F;
                state_next = bta_pkg::S_F_RDN;
            end
            bta_pkg::S_F_RDN:
            begin
                if (st.next_in)
                begin
                    cmd        = bta_pkg::DP_RD_NEXT;
                    state_next = bta_pkg::S_F_CHKN;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = bta_pkg::ST_OK;
                    state_next  = bta_pkg::S_IDLE;
                end
            end
            bta_pkg::S_F_CHKN:
            begin
                if (!st.q_used)
                begin
                    cmd        = bta_pkg::DP_MERGE_NEXT;
                    state_next = bta_pkg::S_F_HDR3;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = bta_pkg::ST_OK;
                    state_next  = bta_pkg::S_IDLE;
                end
            end
            bta_pkg::S_F_HDR3:
            begin
                cmd        = bta_pkg::DP_WR_HDR_F;
                state_next = bta_pkg::S_F_FTR3;
            end
            bta_pkg::S_F_FTR3:
            begin
                cmd         = bta_pkg::DP_WR_FTR_F;
                done_next   = 1'b1;
                status_next = bta_pkg::ST_OK;
                state_next  = bta_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bta_pkg::S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != bta_pkg::S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;

endmodule

// ===== sv/boundary_tag_heap_allocator.sv =====
// Top level of the boundary-tag heap allocator: controller, datapath and ports.
`timescale 1ns / 1ps
// Word-addressed first-fit heap allocator with boundary tags. A command beat is
// taken at a clock edge where start is high and busy is low; its single result
// beat appears on data_addr and status with done high for exactly one cycle,
// and the receiver cannot stall it, so it must sample the result in that
// cycle. After reset the block writes the prologue, the first free block and
// the epilogue into the heap memory, with busy high. The heap memory has one
// write and one registered read port, so the first-fit scan reads each header
// in S_A_RD and checks it in S_A_CHK, the epilogue included when no free block
// fits. An allocate then writes the tags of a block placed whole, or of the
// split block and its free remainder; growing the heap first checks the bound
// and writes a new epilogue, and a failed growth ends at that check. A free
// checks each header on its legality walk, then rewrites the freed block's tags
// and merges it with a free block before and after it. A zero-byte allocate or
// a free of address 0 returns in the next cycle. The result beat appears in the
// cycle after the last step of its command, and a new command may be started
// in that cycle. The growth step register is written through the cfg channel,
// which is always ready; it should be written only while the block is idle.
module boundary_tag_heap_allocator #(
    parameter int HEAP_WORDS = bta_pkg::HEAP_WORDS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        func,
    input  logic [bta_pkg::REQ_W-1:0]   request_bytes,
    input  logic [bta_pkg::ADDR_W-1:0]  free_addr,
    output logic                        done,
    output logic [bta_pkg::ADDR_W-1:0]  data_addr,
    output logic [bta_pkg::STAT_W-1:0]  status,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bta_pkg::GROW_W-1:0]  cfg_data
);

    bta_pkg::dp_cmd_t    cmd;
    bta_pkg::dp_status_t st;

    // The growth step is a plain register, so a write beat is taken at once.
    assign cfg_ready = 1'b1;

    bta_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .st     (st),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .status (status)
    );

    bta_dp #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .func          (func),
        .request_bytes (request_bytes),
        .free_addr     (free_addr),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .st            (st),
        .res_data      (data_addr)
    );

`ifndef NO_ASSERTIONS
    // A zero-byte allocate is answered in the next cycle as ignored.
    a_zero_req: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == bta_pkg::FN_ALLOC && request_bytes == '0)
        |=> (done && status == bta_pkg::ST_IGNORED))
        else $error("zero-size allocate not rejected");

    // Every accepted command either keeps the block busy or returns at once.
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("command dropped");

    // Failed allocates and ignored frees report address zero.
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != bta_pkg::ST_OK) |-> (data_addr == '0))
        else $error("nonzero address on failed request");

    // No result beat while a command is still in progress.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy || $past(start && !busy) || $past(!busy))
        else $error("result during command");
`endif

endmodule
